// ----- rtl/core/iak_pkg.sv -----
// ----------------------------------------------------------------------------
// iak_pkg: shared types and constants of the paddle keyer
// request and result layouts, register indexes, keyer codes
// ----------------------------------------------------------------------------
package iak_pkg;

  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 8;
  localparam int unsigned UnitW       = 8;
  localparam int unsigned DebW        = 8;
  localparam int unsigned CountW      = 12;
  localparam int unsigned ElapsedW    = 10;
  localparam int unsigned MaxReportMs = 3000;

  localparam logic [CfgIdxW-1:0] CFG_UNIT_MS      = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SETTLE_TICKS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MODE_B       = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_STRAIGHT_KEY = 2'd3;

  localparam logic [UnitW-1:0] UNIT_MS_RST      = 8'd60;
  localparam logic [DebW-1:0]  SETTLE_TICKS_RST = 8'd5;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_MARK  = 2'd1,
    PH_SPACE = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    EL_NONE = 2'd0,
    EL_DIT  = 2'd1,
    EL_DAH  = 2'd2
  } element_e;

  typedef struct packed {
    logic raw_dit;
    logic raw_dah;
  } in_t;

  typedef struct packed {
    logic              key_down;
    logic              element_done;
    logic              element_kind;
    logic [CountW-1:0] silence_ms;
    logic [CountW-1:0] mark_ms;
  } out_t;

endpackage

// ----- rtl/core/iak_debounce.sv -----
// ----------------------------------------------------------------------------
// iak_debounce: paddle level debouncer
// a new level must hold for the settle time in further ticks before it is believed
// ----------------------------------------------------------------------------
module iak_debounce (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     raw_i,
  input  logic [iak_pkg::DebW-1:0] settle_ticks_i,
  output logic                     stable_d_o
);
  import iak_pkg::*;

  logic            stable_q, stable_d;
  logic            cand_q, cand_d;
  logic [DebW-1:0] cnt_q, cnt_d;

  always_comb begin
    stable_d = stable_q;
    cand_d   = cand_q;
    cnt_d    = cnt_q;
    if (raw_i != cand_q) begin
      cand_d = raw_i;
      cnt_d  = '0;
    end else if (cand_q != stable_q) begin
      if (cnt_q != '1) begin
        cnt_d = cnt_q + 1'b1;
      end
      if (cnt_d >= settle_ticks_i) begin
        stable_d = cand_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b0;
      cand_q   <= 1'b0;
      cnt_q    <= '0;
    end else if (en_i) begin
      stable_q <= stable_d;
      cand_q   <= cand_d;
      cnt_q    <= cnt_d;
    end
  end

  // the keyer sees the level as updated by this tick
  assign stable_d_o = en_i ? stable_d : stable_q;

endmodule

// ----- rtl/core/iambic_paddle_keyer_top.sv -----
// ----------------------------------------------------------------------------
// iambic_paddle_keyer_top: iambic mode a/b and straight paddle keyer
// input in s1_q, result in out_q; one request per cycle unless out stalls
// each tick is one pass through the keyer logic between two register stages
// async active-low reset restores the power-on configuration and idle keyer
// ----------------------------------------------------------------------------
module iambic_paddle_keyer_top #(
  parameter int unsigned MAX_REPORT_MS = iak_pkg::MaxReportMs
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  iak_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output iak_pkg::out_t                out_data_o,
  input  logic                         cfg_we_i,
  input  logic [iak_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [iak_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import iak_pkg::*;

  localparam logic [CountW-1:0] RepMax = CountW'(MAX_REPORT_MS);

  // configuration
  logic [UnitW-1:0] unit_ms_q;
  logic [DebW-1:0]  settle_ticks_q;
  logic             mode_b_q;
  logic             straight_key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_ms_q      <= UNIT_MS_RST;
      settle_ticks_q <= SETTLE_TICKS_RST;
      mode_b_q       <= 1'b1;
      straight_key_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_UNIT_MS:      unit_ms_q      <= cfg_wdata_i[UnitW-1:0];
        CFG_SETTLE_TICKS: settle_ticks_q <= cfg_wdata_i[DebW-1:0];
        CFG_MODE_B:       mode_b_q       <= cfg_wdata_i[0];
        CFG_STRAIGHT_KEY: straight_key_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // input stage and result stage
  logic s1_valid_q;
  in_t  s1_q;
  logic advance;
  logic out_valid_q;
  out_t out_q, out_d;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // debounced paddles
  logic dit_st, dah_st;

  iak_debounce u_dit_deb (
    .clk_i,
    .rst_ni,
    .en_i           (advance),
    .raw_i          (s1_q.raw_dit),
    .settle_ticks_i (settle_ticks_q),
    .stable_d_o     (dit_st)
  );

  iak_debounce u_dah_deb (
    .clk_i,
    .rst_ni,
    .en_i           (advance),
    .raw_i          (s1_q.raw_dah),
    .settle_ticks_i (settle_ticks_q),
    .stable_d_o     (dah_st)
  );

  // keyer state
  phase_e              phase_q, phase_d;
  logic [ElapsedW-1:0] elapsed_q, elapsed_d;
  element_e            cur_q, cur_d;
  logic                last_dah_q, last_dah_d;
  logic                dit_mem_q, dit_mem_d;
  logic                dah_mem_q, dah_mem_d;
  logic                key_q, key_d;
  logic [CountW-1:0]   mark_q, mark_d;
  logic [CountW-1:0]   gap_q, gap_d;

  logic [ElapsedW-1:0] unit_ext;
  logic [ElapsedW-1:0] mark_len;
  logic                key_off_req;
  logic                key_on_req;
  logic                off_kind;
  element_e            start_el;
  logic                opp_held, opp_mem, same_held;

  assign unit_ext = ElapsedW'(unit_ms_q);

  always_comb begin
    phase_d     = phase_q;
    elapsed_d   = elapsed_q;
    cur_d       = cur_q;
    last_dah_d  = last_dah_q;
    dit_mem_d   = dit_mem_q;
    dah_mem_d   = dah_mem_q;
    key_d       = key_q;
    mark_d      = mark_q;
    gap_d       = gap_q;
    key_off_req = 1'b0;
    key_on_req  = 1'b0;
    off_kind    = 1'b0;
    start_el    = EL_NONE;
    opp_held    = 1'b0;
    opp_mem     = 1'b0;
    same_held   = 1'b0;
    mark_len    = (cur_q == EL_DAH) ? unit_ext * ElapsedW'(3) : unit_ext;

    if (key_q) begin
      if (mark_q != '1) mark_d = mark_q + 1'b1;
    end else begin
      if (gap_q != '1) gap_d = gap_q + 1'b1;
    end

    if (straight_key_q) begin
      if ((dit_st || dah_st) && !key_q) begin
        key_on_req = 1'b1;
      end else if (!(dit_st || dah_st) && key_q) begin
        key_off_req = 1'b1;
        off_kind    = (mark_d >= {3'b000, unit_ms_q, 1'b0});
      end
    end else begin
      case (phase_q)
        PH_MARK, PH_SPACE: begin
          // remember the opposite paddle while an element runs
          if (cur_q == EL_DIT && dah_st) dah_mem_d = 1'b1;
          if (cur_q == EL_DAH && dit_st) dit_mem_d = 1'b1;
          if (elapsed_q != '1) elapsed_d = elapsed_q + 1'b1;
          if (phase_q == PH_MARK) begin
            if (elapsed_d >= mark_len) begin
              key_off_req = 1'b1;
              off_kind    = (cur_q == EL_DAH);
              phase_d     = PH_SPACE;
              elapsed_d   = '0;
            end
          end else if (elapsed_d >= unit_ext) begin
            if (!mode_b_q && !dit_st && !dah_st) begin
              dit_mem_d = 1'b0;
              dah_mem_d = 1'b0;
            end
            opp_held  = last_dah_q ? dit_st : dah_st;
            opp_mem   = last_dah_q ? dit_mem_d : dah_mem_d;
            same_held = last_dah_q ? dah_st : dit_st;
            if (opp_held || opp_mem) begin
              start_el = last_dah_q ? EL_DIT : EL_DAH;
            end else if (same_held) begin
              start_el = last_dah_q ? EL_DAH : EL_DIT;
            end else begin
              phase_d = PH_IDLE;
            end
          end
        end
        default: begin
          phase_d   = PH_IDLE;
          dit_mem_d = 1'b0;
          dah_mem_d = 1'b0;
          if (dit_st) start_el = EL_DIT;
          else if (dah_st) start_el = EL_DAH;
        end
      endcase

      if (start_el != EL_NONE) begin
        cur_d      = start_el;
        last_dah_d = (start_el == EL_DAH);
        phase_d    = PH_MARK;
        elapsed_d  = '0;
        if (start_el == EL_DIT) dit_mem_d = 1'b0;
        else dah_mem_d = 1'b0;
        key_on_req = 1'b1;
      end
    end

    out_d = '0;
    if (key_off_req && key_q) begin
      key_d              = 1'b0;
      out_d.element_done = 1'b1;
      out_d.element_kind = off_kind;
      out_d.silence_ms   = (gap_d > RepMax) ? RepMax : gap_d;
      out_d.mark_ms      = (mark_d > RepMax) ? RepMax : mark_d;
      gap_d              = '0;
    end
    // key_q is still the pre-tick level, so a key-on right after a key-off
    // in the same tick has to test the updated level
    if (key_on_req && !key_d) begin
      key_d  = 1'b1;
      mark_d = '0;
    end
    out_d.key_down = key_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      elapsed_q  <= '0;
      cur_q      <= EL_NONE;
      last_dah_q <= 1'b1;
      dit_mem_q  <= 1'b0;
      dah_mem_q  <= 1'b0;
      key_q      <= 1'b0;
      mark_q     <= '0;
      gap_q      <= '0;
    end else if (advance) begin
      phase_q    <= phase_d;
      elapsed_q  <= elapsed_d;
      cur_q      <= cur_d;
      last_dah_q <= last_dah_d;
      dit_mem_q  <= dit_mem_d;
      dah_mem_q  <= dah_mem_d;
      key_q      <= key_d;
      mark_q     <= mark_d;
      gap_q      <= gap_d;
    end
  end

  // a finished element always leaves the key up
  a_done_key_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.element_done |-> !out_data_o.key_down)
    else $error("element reported while key is down");

  // report fields are quiet between elements
  a_quiet_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.element_done |->
      !out_data_o.element_kind && out_data_o.silence_ms == '0 &&
      out_data_o.mark_ms == '0)
    else $error("report fields set without a finished element");

  // reported times never exceed the clamp
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.silence_ms <= RepMax && out_data_o.mark_ms <= RepMax)
    else $error("reported time above clamp");

  // the keyer state only moves when a result is produced
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(key_q) && $stable(mark_q) && $stable(gap_q))
    else $error("keyer state changed without a request");

endmodule
